>>> hw/rtl/lbjd_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and defaults for the longest backlog job dispatcher
package lbjd_pkg;

    localparam int NUM_QUEUES_DEF   = 4;
    localparam int QUEUE_DEPTH_DEF  = 16;
    localparam int WORKER_LIMIT_DEF = 16;

    localparam int TAG_W   = 16;
    localparam int CFG_W   = 5;
    localparam int CAP_NUM = 4;
    localparam int RUN_W   = 5;

    localparam logic [CFG_W-1:0] WORKER_COUNT_RESET = 5'd4;
    localparam logic [CFG_W-1:0] BACKLOG_RESET      = 5'd16;
    localparam logic [CFG_W-1:0] CAP_RESET          = 5'd16;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_FINISH = 2'd1,
        OP_TICK   = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_REJECT    = 2'd1,
        STAT_UNDERFLOW = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        REG_WORKER_COUNT = 3'd0,
        REG_BACKLOG      = 3'd1,
        REG_CAP0         = 3'd2,
        REG_CAP1         = 3'd3,
        REG_CAP2         = 3'd4,
        REG_CAP3         = 3'd5
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PICK,
        ST_LOAD
    } state_t;

endpackage

>>> hw/rtl/longest_backlog_job_dispatcher.sv
`timescale 1ns / 1ps
// longest backlog job dispatcher: per-queue tag fifos in one memory, longest-queue-first pick
//
// items enter on in_valid/in_ready (opcode, queue_id, job_tag); one result item per input
// item leaves on out_valid/out_ready. configuration goes through the apb port, register i
// at byte address 4*i; it is to be written only while the block is idle, which the block does not enforce.
// each item passes an accept, a pick and a load step: the accept step applies the add or
// finish to the per-queue counters and writes the tag memory, the pick step selects the
// queue and, on a dispatch, issues the memory read of its head tag, the load step moves
// the registered read data into the output register. the block takes a new item only once
// the last one has left the load step.
// the output register holds a finished result while the receiver stalls; the block keeps
// accepting and working on the next item and holds it in the load step until the output
// register is free.
// reset clears all counters and fifo heads, loads the idle pool with the reset worker
// count and sets the registers to their reset values; the tag memory is not cleared.
module longest_backlog_job_dispatcher
    import lbjd_pkg::*;
#(
    parameter int NUM_QUEUES   = NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
    parameter int WORKER_LIMIT = WORKER_LIMIT_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        opcode,
    input  logic [1:0]        queue_id,
    input  logic [TAG_W-1:0]  job_tag,

    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        status,
    output logic              dispatch_valid,
    output logic [1:0]        dispatch_queue,
    output logic [TAG_W-1:0]  dispatch_tag,
    output logic [6:0]        pending_total,
    output logic [4:0]        idle_workers,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int QIW   = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int HW    = $clog2(QUEUE_DEPTH);
    localparam int PW    = $clog2(QUEUE_DEPTH + 1);
    localparam int IW    = $clog2(WORKER_LIMIT + 1);
    localparam int DEPTH = NUM_QUEUES * QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int TW    = $clog2(DEPTH + 1);
    localparam int RTW   = $clog2(NUM_QUEUES * 31 + 1);
    localparam int TP    = (NUM_QUEUES > 1) ? (2 ** $clog2(NUM_QUEUES)) : 1;
    localparam int NODES = 2 * TP - 1;
    localparam int IDLE_RESET_I = (32'(WORKER_COUNT_RESET) > WORKER_LIMIT) ?
                                  WORKER_LIMIT : 32'(WORKER_COUNT_RESET);
    localparam logic [IW-1:0] IDLE_RESET = IW'(IDLE_RESET_I);

    // configuration registers
    logic [CFG_W-1:0] worker_count_reg;
    logic [CFG_W-1:0] backlog_reg;
    logic [CFG_W-1:0] cap_reg [CAP_NUM];

    // per-queue counters
    logic [HW-1:0]    head_reg  [NUM_QUEUES];
    logic [HW-1:0]    head_next [NUM_QUEUES];
    logic [PW-1:0]    pend_reg  [NUM_QUEUES];
    logic [PW-1:0]    pend_next [NUM_QUEUES];
    logic [RUN_W-1:0] run_reg   [NUM_QUEUES];
    logic [RUN_W-1:0] run_next  [NUM_QUEUES];
    logic [IW-1:0]    idle_reg, idle_next;
    logic [TW-1:0]    total_reg, total_next;
    logic [RTW-1:0]   run_total_reg, run_total_next;

    state_t state_reg, state_next;

    // per-item registers
    logic [1:0]       stat_reg, stat_next;
    logic             dv_reg, dv_next;
    logic [QIW-1:0]   dq_reg, dq_next;

    // output register
    logic             out_valid_reg, out_valid_next;
    logic [1:0]       out_status_reg;
    logic             out_dv_reg;
    logic [1:0]       out_dq_reg;
    logic [TAG_W-1:0] out_tag_reg;
    logic [6:0]       out_total_reg;
    logic [4:0]       out_idle_reg;

    // tag memory
    logic [TAG_W-1:0] job_mem [DEPTH];
    logic [TAG_W-1:0] rd_data_reg;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [AW-1:0]    mem_raddr;

    logic             in_fire, pick_en, load_en, disp_go;
    logic             cfg_we;
    logic [2:0]       cfg_idx;
    logic             q_ok;
    logic [QIW-1:0]   qi;

    // pick tree
    logic             node_ok  [NODES];
    logic [PW-1:0]    node_cnt [NODES];
    logic [QIW-1:0]   node_idx [NODES];
    logic             best_ok;
    logic [QIW-1:0]   best_idx;

    function automatic logic [AW-1:0] slot_addr(input logic [QIW-1:0] q,
                                                input logic [HW-1:0] head,
                                                input logic [PW-1:0] off);
        int sum;
        sum = 32'(head) + 32'(off);
        if (sum >= QUEUE_DEPTH)
        begin
            sum = sum - QUEUE_DEPTH;
        end
        return AW'(32'(q) * QUEUE_DEPTH + sum);
    endfunction

    function automatic logic [CFG_W-1:0] cap_of(input int q);
        return cap_reg[(q > CAP_NUM - 1) ? CAP_NUM - 1 : q];
    endfunction

    assign cfg_we  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];
    assign pready  = 1'b1;

    assign q_ok = 32'(queue_id) < NUM_QUEUES;
    assign qi   = QIW'(queue_id);

    // fsm control outputs
    always_comb
    begin
        in_ready = (state_reg == ST_IDLE);
        pick_en  = (state_reg == ST_PICK);
        load_en  = (state_reg == ST_LOAD) && (!out_valid_reg || out_ready);
    end

    assign in_fire = in_valid && in_ready;

    // fsm next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (load_en)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // longest eligible queue, ties toward the lower queue number
    always_comb
    begin
        for (int i = 0; i < TP; i++)
        begin
            if (i < NUM_QUEUES)
            begin
                node_ok[TP-1+i]  = (pend_reg[i] != '0) && (run_reg[i] < cap_of(i));
                node_cnt[TP-1+i] = pend_reg[i];
            end
            else
            begin
                node_ok[TP-1+i]  = 1'b0;
                node_cnt[TP-1+i] = '0;
            end
            node_idx[TP-1+i] = QIW'(i);
        end
        for (int n = TP - 2; n >= 0; n--)
        begin
            if (node_ok[2*n+1] && (!node_ok[2*n+2] || node_cnt[2*n+1] >= node_cnt[2*n+2]))
            begin
                node_ok[n]  = node_ok[2*n+1];
                node_cnt[n] = node_cnt[2*n+1];
                node_idx[n] = node_idx[2*n+1];
            end
            else
            begin
                node_ok[n]  = node_ok[2*n+2];
                node_cnt[n] = node_cnt[2*n+2];
                node_idx[n] = node_idx[2*n+2];
            end
        end
        best_ok  = node_ok[0];
        best_idx = node_idx[0];
    end

    assign disp_go   = pick_en && (idle_reg != '0) && best_ok;
    assign mem_raddr = slot_addr(best_idx, head_reg[best_idx], '0);

    // counter updates: the event at accept, the dispatch in the pick step
    always_comb
    begin
        logic [IW:0] pool;
        head_next      = head_reg;
        pend_next      = pend_reg;
        run_next       = run_reg;
        idle_next      = idle_reg;
        total_next     = total_reg;
        run_total_next = run_total_reg;
        stat_next      = stat_reg;
        dv_next        = dv_reg;
        dq_next        = dq_reg;
        mem_we         = 1'b0;
        mem_waddr      = slot_addr(qi, head_reg[qi], pend_reg[qi]);
        pool           = '0;

        if (in_fire)
        begin
            stat_next = STAT_OK;
            case (opcode)
                OP_ADD:
                begin
                    if (!q_ok || 32'(pend_reg[qi]) >= QUEUE_DEPTH ||
                        (queue_id == '0 && 32'(pend_reg[0]) >= 32'(backlog_reg)))
                    begin
                        stat_next = STAT_REJECT;
                    end
                    else
                    begin
                        mem_we         = 1'b1;
                        pend_next[qi]  = pend_reg[qi] + 1'b1;
                        total_next     = total_reg + 1'b1;
                    end
                end
                OP_FINISH:
                begin
                    if (!q_ok || run_reg[qi] == '0)
                    begin
                        stat_next = STAT_UNDERFLOW;
                    end
                    else
                    begin
                        run_next[qi]   = run_reg[qi] - 1'b1;
                        run_total_next = run_total_reg - 1'b1;
                        if (32'(idle_reg) < WORKER_LIMIT)
                        begin
                            idle_next = idle_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    stat_next = STAT_OK;
                end
            endcase
        end

        if (pick_en)
        begin
            dv_next = disp_go;
            dq_next = disp_go ? best_idx : '0;
            if (disp_go)
            begin
                head_next[best_idx] = (32'(head_reg[best_idx]) == QUEUE_DEPTH - 1) ?
                                      '0 : head_reg[best_idx] + 1'b1;
                pend_next[best_idx] = pend_reg[best_idx] - 1'b1;
                run_next[best_idx]  = run_reg[best_idx] + 1'b1;
                idle_next           = idle_reg - 1'b1;
                total_next          = total_reg - 1'b1;
                run_total_next      = run_total_reg + 1'b1;
            end
        end

        // pool resize: free workers are the pool minus the running jobs
        if (cfg_we && cfg_idx == REG_WORKER_COUNT)
        begin
            pool = (32'(pwdata[CFG_W-1:0]) > WORKER_LIMIT) ? (IW+1)'(WORKER_LIMIT) :
                   (IW+1)'(pwdata[CFG_W-1:0]);
            idle_next = (32'(pool) > 32'(run_total_reg)) ?
                        IW'(32'(pool) - 32'(run_total_reg)) : '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_en)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            idle_reg      <= IDLE_RESET;
            total_reg     <= '0;
            run_total_reg <= '0;
            stat_reg      <= STAT_OK;
            dv_reg        <= 1'b0;
            dq_reg        <= '0;
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                head_reg[i] <= '0;
                pend_reg[i] <= '0;
                run_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            idle_reg      <= idle_next;
            total_reg     <= total_next;
            run_total_reg <= run_total_next;
            stat_reg      <= stat_next;
            dv_reg        <= dv_next;
            dq_reg        <= dq_next;
            head_reg      <= head_next;
            pend_reg      <= pend_next;
            run_reg       <= run_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            worker_count_reg <= WORKER_COUNT_RESET;
            backlog_reg      <= BACKLOG_RESET;
            for (int i = 0; i < CAP_NUM; i++)
            begin
                cap_reg[i] <= CAP_RESET;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_WORKER_COUNT: worker_count_reg <= pwdata[CFG_W-1:0];
                REG_BACKLOG:      backlog_reg      <= pwdata[CFG_W-1:0];
                REG_CAP0:         cap_reg[0]       <= pwdata[CFG_W-1:0];
                REG_CAP1:         cap_reg[1]       <= pwdata[CFG_W-1:0];
                REG_CAP2:         cap_reg[2]       <= pwdata[CFG_W-1:0];
                REG_CAP3:         cap_reg[3]       <= pwdata[CFG_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_WORKER_COUNT: prdata = 32'(worker_count_reg);
            REG_BACKLOG:      prdata = 32'(backlog_reg);
            REG_CAP0:         prdata = 32'(cap_reg[0]);
            REG_CAP1:         prdata = 32'(cap_reg[1]);
            REG_CAP2:         prdata = 32'(cap_reg[2]);
            REG_CAP3:         prdata = 32'(cap_reg[3]);
            default:          prdata = '0;
        endcase
    end

    // tag memory: one write port at accept, one registered read port at pick
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            job_mem[mem_waddr] <= job_tag;
        end
        if (disp_go)
        begin
            rd_data_reg <= job_mem[mem_raddr];
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            out_status_reg <= stat_reg;
            out_dv_reg     <= dv_reg;
            out_dq_reg     <= 2'(dq_reg);
            out_tag_reg    <= dv_reg ? rd_data_reg : '0;
            out_total_reg  <= 7'(total_reg);
            out_idle_reg   <= 5'(idle_reg);
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign dispatch_valid = out_dv_reg;
    assign dispatch_queue = out_dq_reg;
    assign dispatch_tag   = out_tag_reg;
    assign pending_total  = out_total_reg;
    assign idle_workers   = out_idle_reg;

    // an accepted item always moves on to the pick step
    a_accept_to_pick: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg == ST_PICK)
        else $error("accepted item did not enter pick step");

    // a dispatch uses up one idle worker
    a_dispatch_takes_worker: assert property (@(posedge clk) disable iff (!rst_n)
        disp_go |=> idle_reg < $past(idle_reg))
        else $error("dispatch did not take a worker");

    // a result without a dispatch carries no queue and no tag
    a_no_dispatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !dispatch_valid) |-> (dispatch_tag == '0 && dispatch_queue == '0))
        else $error("empty dispatch carries data");

    // the pick step never leaves the input open
    a_pick_closed: assert property (@(posedge clk) disable iff (!rst_n)
        $past(in_fire) |-> !in_ready)
        else $error("input open during pick step");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the longest backlog job dispatcher
module tb;
    import lbjd_pkg::*;

    localparam int NQ          = NUM_QUEUES_DEF;
    localparam int QD          = QUEUE_DEPTH_DEF;
    localparam int MW          = WORKER_LIMIT_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int EXP_DEPTH   = 64;
    localparam logic [1:0] OP_SPARE = 2'd3;   // unused code, behaves like a tick

    typedef struct packed {
        logic [1:0]       status;
        logic             dispatch_valid;
        logic [1:0]       dispatch_queue;
        logic [TAG_W-1:0] dispatch_tag;
        logic [6:0]       pending_total;
        logic [4:0]       idle_workers;
    } dispatch_result_t;

    logic             clk      = 1'b0;
    logic             rst_n    = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic [1:0]       opcode   = OP_TICK;
    logic [1:0]       queue_id = '0;
    logic [TAG_W-1:0] job_tag  = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [1:0]       status;
    logic             dispatch_valid;
    logic [1:0]       dispatch_queue;
    logic [TAG_W-1:0] dispatch_tag;
    logic [6:0]       pending_total;
    logic [4:0]       idle_workers;
    logic             psel    = 1'b0;
    logic             penable = 1'b0;
    logic             pwrite  = 1'b0;
    logic [4:0]       paddr   = '0;
    logic [31:0]      pwdata  = '0;
    logic [31:0]      prdata;
    logic             pready;

    // dispatcher model state
    logic [TAG_W-1:0] tag_mem [NQ][QD];
    int unsigned      head_ptr [NQ];
    int unsigned      pend_cnt [NQ];
    int unsigned      run_cnt [NQ];
    int unsigned      free_workers;
    int unsigned      worker_cfg;
    int unsigned      backlog_cfg;
    int unsigned      cap_cfg [CAP_NUM];

    // expected results in order of acceptance
    dispatch_result_t expected_dispatches [EXP_DEPTH];
    int unsigned      exp_wr_count = 0;
    int unsigned      exp_rd_count = 0;

    int          send_gap_max = 17;
    int          stall_max    = 17;
    int          hold_cycles  = 0;
    int          n_items      = 0;
    int          n_checked    = 0;
    int          n_dispatched = 0;
    int          n_rejected   = 0;
    int          n_underflow  = 0;
    int          n_errors     = 0;
    int unsigned cycle_count  = 0;

    longest_backlog_job_dispatcher i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .queue_id       (queue_id),
        .job_tag        (job_tag),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .dispatch_valid (dispatch_valid),
        .dispatch_queue (dispatch_queue),
        .dispatch_tag   (dispatch_tag),
        .pending_total  (pending_total),
        .idle_workers   (idle_workers),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    function automatic void reset_model();
        worker_cfg  = 32'(WORKER_COUNT_RESET);
        backlog_cfg = 32'(BACKLOG_RESET);
        for (int i = 0; i < CAP_NUM; i++)
            cap_cfg[i] = 32'(CAP_RESET);
        for (int i = 0; i < NQ; i++)
        begin
            head_ptr[i] = 0;
            pend_cnt[i] = 0;
            run_cnt[i]  = 0;
        end
        free_workers = (worker_cfg > MW) ? MW : worker_cfg;
    endfunction

    function automatic void apply_reg(reg_idx_t idx, int unsigned v);
        int unsigned busy;
        int unsigned pool;
        busy = 0;
        case (idx)
            REG_WORKER_COUNT:
            begin
                worker_cfg = v;
                for (int i = 0; i < NQ; i++)
                    busy += run_cnt[i];
                pool = (v > MW) ? MW : v;
                free_workers = (pool > busy) ? pool - busy : 0;
            end
            REG_BACKLOG: backlog_cfg = v;
            default:     cap_cfg[idx - REG_CAP0] = v;
        endcase
    endfunction

    // applies one event, then hands the head of the longest eligible queue to a worker
    function automatic dispatch_result_t predict_dispatch(logic [1:0] op, logic [1:0] q,
                                                          logic [TAG_W-1:0] tag);
        dispatch_result_t r;
        int unsigned      best;
        int unsigned      most;
        int unsigned      total;
        r     = '0;
        best  = 0;
        most  = 0;
        total = 0;
        if (op == OP_ADD)
        begin
            if (pend_cnt[q] >= QD || (q == 0 && pend_cnt[0] >= backlog_cfg))
                r.status = STAT_REJECT;
            else
            begin
                tag_mem[q][(head_ptr[q] + pend_cnt[q]) % QD] = tag;
                pend_cnt[q]++;
            end
        end
        else if (op == OP_FINISH)
        begin
            if (run_cnt[q] == 0)
                r.status = STAT_UNDERFLOW;
            else
            begin
                run_cnt[q]--;
                if (free_workers < MW)
                    free_workers++;
            end
        end
        if (free_workers > 0)
        begin
            // strict compare keeps the lowest queue on a tie
            for (int i = 0; i < NQ; i++)
                if (run_cnt[i] < cap_cfg[(i > CAP_NUM - 1) ? CAP_NUM - 1 : i] &&
                    pend_cnt[i] > most)
                begin
                    most = pend_cnt[i];
                    best = i;
                end
            if (most > 0)
            begin
                r.dispatch_valid = 1'b1;
                r.dispatch_queue = best[1:0];
                r.dispatch_tag   = tag_mem[best][head_ptr[best]];
                head_ptr[best]   = (head_ptr[best] + 1) % QD;
                pend_cnt[best]--;
                run_cnt[best]++;
                free_workers--;
            end
        end
        for (int i = 0; i < NQ; i++)
            total += pend_cnt[i];
        r.pending_total = total[6:0];
        r.idle_workers  = free_workers[4:0];
        return r;
    endfunction

    task automatic send_job(logic [1:0] op, logic [1:0] q, logic [TAG_W-1:0] tag);
        int               gap;
        dispatch_result_t r;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        queue_id <= q;
        job_tag  <= tag;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        r = predict_dispatch(op, q, tag);
        expected_dispatches[exp_wr_count % EXP_DEPTH] = r;
        exp_wr_count++;
        n_items++;
        if (r.dispatch_valid)
            n_dispatched++;
        if (r.status == STAT_REJECT)
            n_rejected++;
        if (r.status == STAT_UNDERFLOW)
            n_underflow++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (exp_wr_count != exp_rd_count)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, int unsigned v);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        apply_reg(idx, v);
        @(posedge clk);
    endtask

    task automatic write_config(int unsigned workers, int unsigned backlog, int unsigned c0,
                                int unsigned c1, int unsigned c2, int unsigned c3);
        write_reg(REG_WORKER_COUNT, workers);
        write_reg(REG_BACKLOG, backlog);
        write_reg(REG_CAP0, c0);
        write_reg(REG_CAP1, c1);
        write_reg(REG_CAP2, c2);
        write_reg(REG_CAP3, c3);
    endtask

    function automatic int unsigned pick_cfg();
        int unsigned sel;
        sel = $urandom_range(0, 3);
        if (sel == 0)
            return 0;
        if (sel == 1)
            return MW;
        return $urandom_range(0, MW);
    endfunction

    task automatic random_job();
        int          pick;
        int unsigned q;
        int unsigned probe;
        pick = $urandom_range(0, 99);
        q    = $urandom_range(0, NQ - 1);
        if (pick < 45)
            send_job(OP_ADD, 2'(q), 16'($urandom));
        else if (pick < 80)
        begin
            // finishes mostly land on a queue that has work running
            if ($urandom_range(0, 4) != 0)
                for (int i = 0; i < NQ; i++)
                begin
                    probe = (q + i) % NQ;
                    if (run_cnt[probe] > 0)
                    begin
                        q = probe;
                        break;
                    end
                end
            send_job(OP_FINISH, 2'(q), 16'($urandom));
        end
        else if (pick < 95)
            send_job(OP_TICK, 2'(q), 16'($urandom));
        else
            send_job(OP_SPARE, 2'(q), 16'($urandom));
    endtask

    task automatic test_basic_ops();
        send_job(OP_TICK, 2'd0, 16'h0000);
        send_job(OP_SPARE, 2'd3, 16'hffff);
        send_job(OP_FINISH, 2'd1, 16'h0000);  // nothing running
        send_job(OP_ADD, 2'd0, 16'hffff);
        send_job(OP_ADD, 2'd3, 16'h0000);
        send_job(OP_FINISH, 2'd0, 16'h1234);
        send_job(OP_FINISH, 2'd3, 16'h0000);
        wait_idle();
    endtask

    task automatic test_backlog_and_caps();
        write_config(0, 1, 0, 32'(CAP_RESET), 32'(CAP_RESET), 32'(CAP_RESET));
        send_job(OP_ADD, 2'd0, 16'h00a5);
        send_job(OP_ADD, 2'd0, 16'h5a00);     // over the queue 0 backlog
        send_job(OP_ADD, 2'd1, 16'h1111);
        send_job(OP_ADD, 2'd2, 16'h2222);
        send_job(OP_ADD, 2'd2, 16'h3333);
        write_reg(REG_WORKER_COUNT, 2);
        send_job(OP_TICK, 2'd0, 16'h0000);    // longest queue first
        send_job(OP_TICK, 2'd0, 16'h0000);    // tie, queue 0 held by its cap
        send_job(OP_TICK, 2'd0, 16'h0000);    // pool empty
        send_job(OP_FINISH, 2'd2, 16'h0000);
        write_reg(REG_CAP0, 32'(CAP_RESET));
        send_job(OP_FINISH, 2'd1, 16'h0000);
        wait_idle();
    endtask

    task automatic test_full_queue();
        write_config(0, 32'(BACKLOG_RESET), 32'(CAP_RESET), 32'(CAP_RESET), 32'(CAP_RESET),
                     32'(CAP_RESET));
        repeat (QD + 1)
            send_job(OP_ADD, 2'd2, 16'($urandom));  // last add finds the fifo full
        send_job(OP_ADD, 2'd0, 16'($urandom));
        wait_idle();
    endtask

    task automatic test_backpressure();
        write_config(MW, 32'(BACKLOG_RESET), 32'(CAP_RESET), 32'(CAP_RESET), 32'(CAP_RESET),
                     32'(CAP_RESET));
        send_gap_max = 0;
        hold_cycles  = 200;
        repeat (60)
            random_job();
        send_gap_max = 17;
        wait_idle();
    endtask

    task automatic test_random_phases();
        for (int p = 0; p < 10; p++)
        begin
            case (p)
                0:       write_config(MW, MW, MW, MW, MW, MW);
                1:       write_config(0, 0, 0, 0, 0, 0);
                2:       write_config(1, 1, 1, 1, 1, 1);
                default: write_config(pick_cfg(), pick_cfg(), pick_cfg(), pick_cfg(),
                                      pick_cfg(), pick_cfg());
            endcase
            send_gap_max = (p % 3 == 1) ? 0 : 17;
            stall_max    = (p % 4 == 2) ? 0 : 17;
            repeat (85)
                random_job();
        end
        send_gap_max = 17;
        stall_max    = 17;
        wait_idle();
    endtask

    initial
    begin : result_checker
        dispatch_result_t want;
        int               stall;
        @(posedge rst_n);
        forever
        begin
            if (hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            stall = $urandom_range(0, stall_max);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            if (exp_wr_count == exp_rd_count)
            begin
                $error("result item arrived with no expectation waiting");
                n_errors++;
            end
            else
            begin
                want = expected_dispatches[exp_rd_count % EXP_DEPTH];
                exp_rd_count++;
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    n_errors++;
                end
                if (dispatch_valid !== want.dispatch_valid)
                begin
                    $error("dispatch_valid: expected %0d, got %0d",
                           want.dispatch_valid, dispatch_valid);
                    n_errors++;
                end
                if (dispatch_queue !== want.dispatch_queue)
                begin
                    $error("dispatch_queue: expected %0d, got %0d",
                           want.dispatch_queue, dispatch_queue);
                    n_errors++;
                end
                if (dispatch_tag !== want.dispatch_tag)
                begin
                    $error("dispatch_tag: expected %h, got %h", want.dispatch_tag, dispatch_tag);
                    n_errors++;
                end
                if (pending_total !== want.pending_total)
                begin
                    $error("pending_total: expected %0d, got %0d",
                           want.pending_total, pending_total);
                    n_errors++;
                end
                if (idle_workers !== want.idle_workers)
                begin
                    $error("idle_workers: expected %0d, got %0d",
                           want.idle_workers, idle_workers);
                    n_errors++;
                end
                n_checked++;
            end
        end
    end

    initial
    begin
        reset_model();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_ops();
        test_backlog_and_caps();
        test_full_queue();
        test_backpressure();
        test_random_phases();
        wait_idle();
        $display("tb: %0d items sent, %0d results checked over 13 register settings",
                 n_items, n_checked);
        $display("tb: %0d jobs dispatched, %0d adds rejected, %0d finishes with none running",
                 n_dispatched, n_rejected, n_underflow);
        if (n_errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

>>> longest_backlog_job_dispatcher.f
hw/rtl/lbjd_pkg.sv
hw/rtl/longest_backlog_job_dispatcher.sv
tb/tb.sv
